// File: rtl/spa_pkg.sv
// Package for the slab pool allocator: codes, list state type and list functions.
package spa_pkg;

    localparam int SLAB_SLOTS_DEF  = 16;
    localparam int MAX_OBJECTS_DEF = 64;
    localparam int LINK_DEPTH      = 32;

    localparam logic [4:0] NONE_SLAB = 5'd31;
    localparam logic [6:0] NONE_OBJ  = 7'd127;

    localparam logic [1:0] LST_PART     = 2'd0;
    localparam logic [1:0] LST_ALLFREE  = 2'd1;
    localparam logic [1:0] LST_NONEFREE = 2'd2;

    localparam logic [1:0] STAT_DONE     = 2'd0;
    localparam logic [1:0] STAT_NO_SLOT  = 2'd1;
    localparam logic [1:0] STAT_FREE_ERR = 2'd2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic CFG_OBJECTS = 1'b0;
    localparam logic CFG_LIMIT   = 1'b1;

    typedef struct packed {
        logic [LINK_DEPTH-1:0][4:0] prev;
        logic [LINK_DEPTH-1:0][4:0] next;
        logic [2:0][4:0]            first;
        logic [2:0][4:0]            last;
    } lst_t;

    function automatic lst_t lst_unlink(lst_t x, logic [1:0] l, logic [4:0] s);
        logic [4:0] p;
        logic [4:0] n;
        p = x.prev[s];
        n = x.next[s];
        if (p == NONE_SLAB) x.first[l] = n; else x.next[p] = n;
        if (n == NONE_SLAB) x.last[l] = p; else x.prev[n] = p;
        return x;
    endfunction

    function automatic lst_t lst_push_head(lst_t x, logic [1:0] l, logic [4:0] s);
        logic [4:0] f;
        f = x.first[l];
        x.prev[s] = NONE_SLAB;
        x.next[s] = f;
        if (f == NONE_SLAB) x.last[l] = s; else x.prev[f] = s;
        x.first[l] = s;
        return x;
    endfunction

    function automatic lst_t lst_push_tail(lst_t x, logic [1:0] l, logic [4:0] s);
        logic [4:0] t;
        t = x.last[l];
        x.next[s] = NONE_SLAB;
        x.prev[s] = t;
        if (t == NONE_SLAB) x.first[l] = s; else x.next[t] = s;
        x.last[l] = s;
        return x;
    endfunction

    function automatic lst_t lst_insert_after(lst_t x, logic [4:0] s, logic [4:0] p);
        logic [4:0] n;
        n = x.next[p];
        x.prev[s] = p;
        x.next[s] = n;
        x.next[p] = s;
        if (n != NONE_SLAB) x.prev[n] = s; else x.last[LST_PART] = s;
        return x;
    endfunction

endpackage

// File: rtl/spa_ram.sv
// Generic single-port-write, registered-read RAM.
module spa_ram
#(
    parameter int WIDTH = 7,
    parameter int DEPTH = 1024
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/slab_pool_allocator.sv
// Slab pool allocator top level: request sequencer, slab lists and free-chain RAM.
// Alloc takes an object from a partial or revived all-free slab, or first builds a new
// slab's free chain (one RAM write a cycle). A free that is refused or moves lists skips
// the walk; else it walks back along the partial list past slabs with more objects in use.
// One item in flight; next input accepted the cycle after the result is registered,
// a held result stalls the next one. Reset (rst_n low, asynchronous) empties all lists.
module slab_pool_allocator
    import spa_pkg::*;
#(
    parameter int SLAB_SLOTS  = SLAB_SLOTS_DEF,
    parameter int MAX_OBJECTS = MAX_OBJECTS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // slab_index[3:0], object_index[9:4], zero pad
    input  logic        s_axis_tuser,  // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // given_slab[3:0], given_object[9:4], zero pad
    output logic [1:0]  m_axis_tuser,  // status
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_data
);

    localparam int DEPTH = SLAB_SLOTS * MAX_OBJECTS;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = $clog2(SLAB_SLOTS);
    localparam int CAP   = (MAX_OBJECTS < 64) ? MAX_OBJECTS : 64;

    typedef enum logic [8:0] {
        ST_IDLE    = 9'b000000001,
        ST_A_START = 9'b000000010,
        ST_A_BUILD = 9'b000000100,
        ST_A_HEAD  = 9'b000001000,
        ST_A_RD    = 9'b000010000,
        ST_F_START = 9'b000100000,
        ST_F_WALK  = 9'b001000000,
        ST_F_PLACE = 9'b010000000,
        ST_DONE    = 9'b100000000
    } state_t;

    state_t     state_reg, state_next;
    lst_t       lst_reg, lst_next;
    logic [6:0] head_reg [SLAB_SLOTS];
    logic [6:0] head_next [SLAB_SLOTS];
    logic [6:0] used_reg [SLAB_SLOTS];
    logic [6:0] used_next [SLAB_SLOTS];
    logic [4:0] made_reg, made_next;
    logic [6:0] ops_reg, ops_next;
    logic [4:0] lim_reg, lim_next;
    logic       op_reg, op_next;
    logic [4:0] s_reg, s_next;
    logic [5:0] obj_reg, obj_next;
    logic [6:0] h_reg, h_next;
    logic [4:0] p_reg, p_next;
    logic [6:0] i_reg, i_next;
    logic [1:0] rs_reg, rs_next;
    logic       ov_reg, ov_next;
    logic [15:0] od_reg, od_next;
    logic [1:0] ou_reg, ou_next;

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [6:0]    ram_wdata, ram_rdata;

    logic [6:0] n_obj;
    logic [4:0] lim_eff;

    assign n_obj   = (ops_reg == 7'd0) ? 7'd1 : ((ops_reg > 7'(CAP)) ? 7'(CAP) : ops_reg);
    assign lim_eff = (lim_reg > 5'(SLAB_SLOTS)) ? 5'(SLAB_SLOTS) : lim_reg;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = od_reg;
    assign m_axis_tuser  = ou_reg;

    spa_ram #(.WIDTH(7), .DEPTH(DEPTH)) u_next_ram
    (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        logic [4:0] s;
        logic [6:0] h;
        logic [6:0] old;
        logic [6:0] cnt;
        state_next = state_reg;
        lst_next   = lst_reg;
        head_next  = head_reg;
        used_next  = used_reg;
        made_next  = made_reg;
        ops_next   = ops_reg;
        lim_next   = lim_reg;
        op_next    = op_reg;
        s_next     = s_reg;
        obj_next   = obj_reg;
        h_next     = h_reg;
        p_next     = p_reg;
        i_next     = i_reg;
        rs_next    = rs_reg;
        ov_next    = ov_reg;
        od_next    = od_reg;
        ou_next    = ou_reg;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_waddr  = '0;
        ram_raddr  = '0;
        ram_wdata  = '0;
        s          = s_reg;
        h          = '0;
        old        = '0;
        cnt        = '0;

        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_OBJECTS: ops_next = cfg_data;
                CFG_LIMIT:   lim_next = cfg_data[4:0];
                default:     ;
            endcase
        end

        if (ov_reg && m_axis_tready)
        begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    op_next    = s_axis_tuser;
                    s_next     = {1'b0, s_axis_tdata[3:0]};
                    obj_next   = s_axis_tdata[9:4];
                    rs_next    = STAT_DONE;
                    h_next     = '0;
                    state_next = (s_axis_tuser == OP_ALLOC) ? ST_A_START : ST_F_START;
                end
            end
            ST_A_START:
            begin
                if (lst_reg.first[LST_PART] != NONE_SLAB)
                begin
                    state_next = ST_A_HEAD;
                end
                else if (lst_reg.first[LST_ALLFREE] != NONE_SLAB)
                begin
                    s          = lst_reg.first[LST_ALLFREE];
                    lst_next   = lst_push_tail(lst_unlink(lst_reg, LST_ALLFREE, s), LST_PART, s);
                    state_next = ST_A_HEAD;
                end
                else if (made_reg >= lim_eff)
                begin
                    rs_next    = STAT_NO_SLOT;
                    state_next = ST_DONE;
                end
                else
                begin
                    s                    = made_reg;
                    s_next               = s;
                    made_next            = made_reg + 5'd1;
                    head_next[s[SW-1:0]] = 7'd0;
                    used_next[s[SW-1:0]] = 7'd0;
                    lst_next             = lst_push_tail(lst_reg, LST_PART, s);
                    i_next               = 7'd0;
                    state_next           = ST_A_BUILD;
                end
            end
            ST_A_BUILD:
            begin
                ram_we    = 1'b1;
                ram_waddr = AW'(s_reg) * AW'(MAX_OBJECTS) + AW'(i_reg);
                ram_wdata = (i_reg + 7'd1 < n_obj) ? i_reg + 7'd1 : NONE_OBJ;
                i_next    = i_reg + 7'd1;
                if (i_reg + 7'd1 >= n_obj)
                begin
                    state_next = ST_A_HEAD;
                end
            end
            ST_A_HEAD:
            begin
                s = lst_reg.last[LST_PART];
                if (s >= 5'(SLAB_SLOTS))
                begin
                    rs_next    = STAT_NO_SLOT;
                    state_next = ST_DONE;
                end
                else
                begin
                    h = head_reg[s[SW-1:0]];
                    if (h >= 7'(MAX_OBJECTS))
                    begin
                        rs_next    = STAT_NO_SLOT;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        s_next     = s;
                        h_next     = h;
                        ram_re     = 1'b1;
                        ram_raddr  = AW'(s) * AW'(MAX_OBJECTS) + AW'(h);
                        state_next = ST_A_RD;
                    end
                end
            end
            ST_A_RD:
            begin
                head_next[s_reg[SW-1:0]] = ram_rdata;
                used_next[s_reg[SW-1:0]] = used_reg[s_reg[SW-1:0]] + 7'd1;
                if (ram_rdata == NONE_OBJ)
                begin
                    lst_next = lst_push_head(lst_unlink(lst_reg, LST_PART, s_reg),
                                             LST_NONEFREE, s_reg);
                end
                state_next = ST_DONE;
            end
            ST_F_START:
            begin
                if (s_reg >= made_reg || s_reg >= 5'(SLAB_SLOTS))
                begin
                    rs_next    = STAT_FREE_ERR;
                    state_next = ST_DONE;
                end
                else if (used_reg[s_reg[SW-1:0]] == 7'd0)
                begin
                    rs_next    = STAT_FREE_ERR;
                    state_next = ST_DONE;
                end
                else if ({1'b0, obj_reg} >= n_obj)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    old                      = head_reg[s_reg[SW-1:0]];
                    cnt                      = used_reg[s_reg[SW-1:0]] - 7'd1;
                    ram_we                   = 1'b1;
                    ram_waddr                = AW'(s_reg) * AW'(MAX_OBJECTS) + AW'(obj_reg);
                    ram_wdata                = old;
                    head_next[s_reg[SW-1:0]] = {1'b0, obj_reg};
                    used_next[s_reg[SW-1:0]] = cnt;
                    if (old == NONE_OBJ)
                    begin
                        lst_next   = lst_push_tail(lst_unlink(lst_reg, LST_NONEFREE, s_reg),
                                                   LST_PART, s_reg);
                        state_next = ST_DONE;
                    end
                    else if (cnt == 7'd0)
                    begin
                        lst_next   = lst_push_head(lst_unlink(lst_reg, LST_PART, s_reg),
                                                   LST_ALLFREE, s_reg);
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        p_next     = lst_reg.prev[s_reg];
                        state_next = ST_F_WALK;
                    end
                end
            end
            ST_F_WALK:
            begin
                if (p_reg != NONE_SLAB
                    && used_reg[s_reg[SW-1:0]] < used_reg[p_reg[SW-1:0]])
                begin
                    p_next = lst_reg.prev[p_reg];
                end
                else
                begin
                    state_next = ST_F_PLACE;
                end
            end
            ST_F_PLACE:
            begin
                if (p_reg != lst_reg.prev[s_reg])
                begin
                    if (p_reg == NONE_SLAB)
                    begin
                        lst_next = lst_push_head(lst_unlink(lst_reg, LST_PART, s_reg),
                                                 LST_PART, s_reg);
                    end
                    else
                    begin
                        lst_next = lst_insert_after(lst_unlink(lst_reg, LST_PART, s_reg),
                                                    s_reg, p_reg);
                    end
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!ov_reg || m_axis_tready)
                begin
                    ov_next = 1'b1;
                    ou_next = rs_reg;
                    if (op_reg == OP_ALLOC && rs_reg == STAT_DONE)
                    begin
                        od_next = {6'd0, h_reg[5:0], s_reg[3:0]};
                    end
                    else
                    begin
                        od_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            lst_reg   <= '1;
            made_reg  <= '0;
            ops_reg   <= 7'd64;
            lim_reg   <= 5'd16;
            ov_reg    <= 1'b0;
            for (int k = 0; k < SLAB_SLOTS; k++)
            begin
                head_reg[k] <= NONE_OBJ;
                used_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            lst_reg   <= lst_next;
            made_reg  <= made_next;
            ops_reg   <= ops_next;
            lim_reg   <= lim_next;
            ov_reg    <= ov_next;
            head_reg  <= head_next;
            used_reg  <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        s_reg   <= s_next;
        obj_reg <= obj_next;
        h_reg   <= h_next;
        p_reg   <= p_next;
        i_reg   <= i_next;
        rs_reg  <= rs_next;
        od_reg  <= od_next;
        ou_reg  <= ou_next;
    end

`ifndef SYNTHESIS
    a_made_bound: assert property (@(posedge clk) disable iff (!rst_n)
        made_reg <= 5'(SLAB_SLOTS))
        else $error("slab count beyond slots");
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser != 2'd3))
        else $error("bad status code");
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != STAT_DONE) |-> (m_axis_tdata == 16'd0))
        else $error("failed result carries data");
    a_build_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_A_START && state_next == ST_A_BUILD)
        |=> (made_reg == $past(made_reg) + 5'd1))
        else $error("new slab not counted");
`endif

endmodule

// File: bench/spa_checker.sv
`timescale 1ns / 100ps
// Checker for the slab pool allocator: watches the channels, predicts and compares results.
module spa_checker
    import spa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,
    input  logic        s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,
    input  logic [1:0]  m_axis_tuser,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_data,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] slab;
        logic [5:0] obj;
    } grant_t;

    logic [6:0] chain_next [0:1023];
    logic [6:0] chain_head [0:31];
    logic [6:0] in_use     [0:31];
    logic [4:0] lprev      [0:31];
    logic [4:0] lnext      [0:31];
    logic [4:0] lfirst     [0:2];
    logic [4:0] llast      [0:2];
    logic [4:0] made;
    logic [6:0] obj_reg;
    logic [4:0] lim_reg;
    grant_t     grants_due [$];

    function automatic int per_slab();
        int n;
        n = int'(obj_reg);
        if (n < 1) n = 1;
        if (n > 64) n = 64;
        return n;
    endfunction

    function automatic void unlink(int l, logic [4:0] s);
        logic [4:0] p;
        logic [4:0] n;
        p = lprev[s];
        n = lnext[s];
        if (p == NONE_SLAB) lfirst[l] = n; else lnext[p] = n;
        if (n == NONE_SLAB) llast[l] = p; else lprev[n] = p;
    endfunction

    function automatic void to_head(int l, logic [4:0] s);
        logic [4:0] f;
        f = lfirst[l];
        lprev[s] = NONE_SLAB;
        lnext[s] = f;
        if (f == NONE_SLAB) llast[l] = s; else lprev[f] = s;
        lfirst[l] = s;
    endfunction

    function automatic void to_tail(int l, logic [4:0] s);
        logic [4:0] t;
        t = llast[l];
        lnext[s] = NONE_SLAB;
        lprev[s] = t;
        if (t == NONE_SLAB) lfirst[l] = s; else lnext[t] = s;
        llast[l] = s;
    endfunction

    function automatic grant_t grant_object();
        grant_t g;
        logic [4:0] s;
        logic [6:0] h;
        int n;
        int lim;
        g = '0;
        if (lfirst[LST_PART] == NONE_SLAB) begin
            if (lfirst[LST_ALLFREE] != NONE_SLAB) begin
                s = lfirst[LST_ALLFREE];
                unlink(LST_ALLFREE, s);
                to_tail(LST_PART, s);
            end
            else begin
                lim = int'(lim_reg);
                if (lim > 16) lim = 16;
                if (made >= lim) begin
                    g.status = STAT_NO_SLOT;
                    return g;
                end
                s = made;
                made = made + 5'd1;
                n = per_slab();
                for (int i = 0; i < n; i++)
                    chain_next[s * 64 + i] = (i + 1 < n) ? 7'(i + 1) : NONE_OBJ;
                chain_head[s] = '0;
                in_use[s] = '0;
                to_tail(LST_PART, s);
            end
        end
        s = llast[LST_PART];
        if (s >= 16) begin
            g.status = STAT_NO_SLOT;
            return g;
        end
        h = chain_head[s];
        if (h >= 64) begin
            g.status = STAT_NO_SLOT;
            return g;
        end
        chain_head[s] = chain_next[s * 64 + h];
        in_use[s] = in_use[s] + 7'd1;
        if (chain_head[s] == NONE_OBJ) begin
            unlink(LST_PART, s);
            to_head(LST_NONEFREE, s);
        end
        g.slab = s[3:0];
        g.obj = h[5:0];
        return g;
    endfunction

    function automatic grant_t release_object(logic [4:0] s, logic [6:0] o);
        grant_t g;
        logic [6:0] old;
        logic [4:0] p;
        logic [4:0] n;
        g = '0;
        if (s >= made || in_use[s] == 0) begin
            g.status = STAT_FREE_ERR;
            return g;
        end
        if (o >= per_slab()) return g;
        old = chain_head[s];
        chain_next[s * 64 + o] = old;
        chain_head[s] = o;
        in_use[s] = in_use[s] - 7'd1;
        if (old == NONE_OBJ) begin
            unlink(LST_NONEFREE, s);
            to_tail(LST_PART, s);
            return g;
        end
        if (in_use[s] == 0) begin
            unlink(LST_PART, s);
            to_head(LST_ALLFREE, s);
            return g;
        end
        p = lprev[s];
        while (p != NONE_SLAB && in_use[s] < in_use[p]) p = lprev[p];
        if (p == lprev[s]) return g;
        unlink(LST_PART, s);
        if (p == NONE_SLAB) to_head(LST_PART, s);
        else begin
            n = lnext[p];
            lprev[s] = p;
            lnext[s] = n;
            lnext[p] = s;
            if (n != NONE_SLAB) lprev[n] = s; else llast[LST_PART] = s;
        end
        return g;
    endfunction

    assign pending = grants_due.size();

    always @(posedge clk or negedge rst_n)
    begin
        grant_t exp_g;
        if (!rst_n)
        begin
            fail_count = 0;
            grants_due.delete();
            for (int i = 0; i < 32; i++)
            begin
                chain_head[i] = NONE_OBJ;
                in_use[i] = '0;
                lprev[i] = NONE_SLAB;
                lnext[i] = NONE_SLAB;
            end
            for (int i = 0; i < 3; i++)
            begin
                lfirst[i] = NONE_SLAB;
                llast[i] = NONE_SLAB;
            end
            made = '0;
            obj_reg = 7'd64;
            lim_reg = 5'd16;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_OBJECTS) obj_reg = cfg_data;
                else lim_reg = cfg_data[4:0];
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tuser == OP_ALLOC) grants_due.push_back(grant_object());
                else grants_due.push_back(release_object({1'b0, s_axis_tdata[3:0]},
                                                         {1'b0, s_axis_tdata[9:4]}));
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (grants_due.size() == 0)
                begin
                    $display("%0t: unexpected result status %0d data %h", $time,
                             m_axis_tuser, m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    exp_g = grants_due.pop_front();
                    if (m_axis_tuser !== exp_g.status || m_axis_tdata[3:0] !== exp_g.slab ||
                        m_axis_tdata[9:4] !== exp_g.obj || m_axis_tdata[15:10] !== 6'd0)
                    begin
                        $display("%0t: expected st %0d slab %0d obj %0d, got st %0d data %h",
                                 $time, exp_g.status, exp_g.slab, exp_g.obj,
                                 m_axis_tuser, m_axis_tdata);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for the slab pool allocator: stimulus, idling and verdict.
module tb_top;
    import spa_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [6:0]  cfg_data;
    int          fail_count;
    int          pending;
    int          rx_idle_pct;
    int          hold_cycles;
    logic        hold_go;
    logic        hold_done;
    int          tx_idle_pct;
    logic [9:0]  live [$];
    logic        chk_last_alloc;
    logic        op_fifo [$];

    slab_pool_allocator dut (.*);

    spa_checker chk (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_cycles <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_go && !hold_done)
        begin
            m_axis_tready <= 1'b0;
            hold_cycles <= 400;
            hold_done <= 1'b1;
        end
        else if (hold_cycles > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    task automatic send_item(logic op, logic [3:0] slab, logic [5:0] obj);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {6'd0, obj, slab};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
    endtask

    task automatic alloc_one();
        send_item(OP_ALLOC, 4'($urandom), 6'($urandom));
    endtask

    task automatic free_one(logic [3:0] slab, logic [5:0] obj);
        send_item(OP_FREE, slab, obj);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [6:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        live.delete();
    endtask

    // Freeing needs the slab/object just granted; the checker's queue holds only
    // expectations, so track grants from observed result transfers.
    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready && m_axis_tuser == STAT_DONE &&
            chk_last_alloc)
            live.push_back(m_axis_tdata[9:0]);

    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready) op_fifo.push_back(s_axis_tuser);
    end

    always @(negedge clk)
        chk_last_alloc = (op_fifo.size() != 0) && (op_fifo[0] == OP_ALLOC);

    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready && op_fifo.size() != 0)
            void'(op_fifo.pop_front());

    task automatic random_phase(int count, int free_bias);
        int k;
        logic [9:0] it;
        for (int i = 0; i < count; i++)
        begin
            if (live.size() != 0 && $urandom_range(99) < free_bias)
            begin
                k = $urandom_range(live.size() - 1);
                it = live[k];
                live.delete(k);
                free_one(it[3:0], it[9:4]);
            end
            else if ($urandom_range(99) < 6)
                free_one(4'($urandom), 6'($urandom));
            else
                alloc_one();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = OP_ALLOC;
        cfg_valid = 1'b0;
        cfg_index = CFG_OBJECTS;
        cfg_data = '0;
        rx_idle_pct = 0;
        tx_idle_pct = 0;
        hold_go = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, errors, out-of-range settings
        free_one(4'd0, 6'd0);
        settle();
        write_reg(CFG_OBJECTS, 7'd8);
        write_reg(CFG_LIMIT, 7'd1);
        settle();
        for (int i = 0; i < 9; i++) alloc_one();
        free_one(4'd0, 6'd7);
        free_one(4'd0, 6'd63);
        free_one(4'd15, 6'd0);
        free_one(4'd0, 6'd0);
        free_one(4'd0, 6'd0);
        for (int i = 0; i < 3; i++) alloc_one();
        settle();
        write_reg(CFG_OBJECTS, 7'd0);
        write_reg(CFG_LIMIT, 7'd0);
        settle();
        alloc_one();
        settle();
        write_reg(CFG_OBJECTS, 7'd127);
        write_reg(CFG_LIMIT, 7'd31);
        settle();
        alloc_one();
        alloc_one();
        settle();

        // random phases; reset-free so keep one coherent live set per setting
        tx_idle_pct = 8;
        rx_idle_pct = 82;
        write_reg(CFG_OBJECTS, 7'd8);
        write_reg(CFG_LIMIT, 7'd16);
        settle();
        random_phase(600, 45);
        settle();
        tx_idle_pct = 82;
        rx_idle_pct = 8;
        write_reg(CFG_OBJECTS, 7'd12);
        write_reg(CFG_LIMIT, 7'd16);
        settle();
        random_phase(500, 50);
        settle();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_reg(CFG_OBJECTS, 7'd64);
        write_reg(CFG_LIMIT, 7'd16);
        settle();
        hold_go = 1'b1;
        random_phase(700, 48);
        settle();

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: files.f
rtl/spa_pkg.sv
rtl/spa_ram.sv
rtl/slab_pool_allocator.sv
bench/spa_checker.sv
bench/tb_top.sv
